>>> sv/povst_pkg.sv
package povst_pkg;

    localparam int DEFAULT_SECTOR_COUNT  = 16;
    localparam int DEFAULT_COUNTER_WIDTH = 16;

    localparam int IMAGE_W     = 64;
    localparam int LED_W       = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HIGH = 1'b1;

    localparam logic [IMAGE_W-1:0] IMAGE_LOW_RESET  = 64'd14377396034433368448;
    localparam logic [IMAGE_W-1:0] IMAGE_HIGH_RESET = 64'd40248227845032328;

    function automatic logic [LED_W-1:0] column_pattern(
        input logic [IMAGE_W-1:0] img_low,
        input logic [IMAGE_W-1:0] img_high,
        input logic [3:0]         sector
    );
        logic [IMAGE_W-1:0] word;
        word = sector[3] ? img_high : img_low;
        return word[{sector[2:0], 3'b000} +: LED_W];
    endfunction

endpackage

>>> sv/pov_sector_timing_controller.sv
// A word accepted on the input appears on the output in the next cycle.
// Throughput: one word per cycle while m_tready is high; the output register is
// refilled in the same cycle it is drained, so input and output run back to back.
// Reset (rst_n low, asynchronous): counters and column state clear, the timeout
// flag is set, the LEDs and indicator are off and the image returns to its default.
module pov_sector_timing_controller
    import povst_pkg::*;
#(
    parameter int SECTOR_COUNT  = DEFAULT_SECTOR_COUNT,
    parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [IMAGE_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [0] sensor_active
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // [7:0] led_pattern, [8] indicator_on,
                                              // [9] timed_out
);

    localparam int CW  = COUNTER_WIDTH;
    localparam int RW  = $clog2(SECTOR_COUNT);
    localparam int SIW = $clog2(SECTOR_COUNT + 1);

    localparam logic [CW-1:0]  CNT_MAX  = {CW{1'b1}};
    localparam logic [RW-1:0]  REM_LAST = RW'(SECTOR_COUNT - 1);
    localparam logic [SIW-1:0] IDX_LAST = SIW'(SECTOR_COUNT - 1);

    logic [IMAGE_W-1:0] img_low_reg, img_high_reg;

    logic [CW-1:0]  tick_reg, tick_next;
    logic [CW-1:0]  quo_reg, quo_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic           wrap_reg, wrap_next;
    logic           timeout_reg, timeout_next;
    logic           held_reg, held_next;
    logic           active_reg, active_next;
    logic [CW-1:0]  interval_reg, interval_next;
    logic [CW-1:0]  boundary_reg, boundary_next;
    logic [SIW-1:0] idx_reg, idx_next;
    logic [LED_W-1:0] led_reg, led_next;
    logic           ind_reg, ind_next;
    logic           m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic           accept;
    logic           sensor;
    logic           restart;
    logic [CW-1:0]  tick_mid, quo_mid;
    logic [RW-1:0]  rem_mid;
    logic [SIW+3:0] idx_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign sensor   = s_tdata[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        held_next     = held_reg;
        ind_next      = ind_reg;
        timeout_next  = timeout_reg;
        led_next      = led_reg;
        active_next   = active_reg;
        interval_next = interval_reg;
        boundary_next = boundary_reg;
        idx_next      = idx_reg;
        wrap_next     = wrap_reg;
        restart       = 1'b0;
        idx_ext       = '0;

        if (held_reg)
        begin
            held_next = sensor;
            if (!sensor)
            begin
                ind_next = 1'b0;
            end
        end
        else if (sensor)
        begin
            if (!timeout_reg)
            begin
                active_next   = (tick_reg != '0);
                led_next      = column_pattern(img_low_reg, img_high_reg, 4'd0);
                interval_next = quo_reg;
                boundary_next = quo_reg;
                idx_next      = SIW'(1);
            end
            else
            begin
                timeout_next = 1'b0;
            end
            restart   = 1'b1;
            held_next = 1'b1;
            ind_next  = 1'b1;
        end

        if (wrap_reg)
        begin
            timeout_next = 1'b1;
            led_next     = '0;
            active_next  = 1'b0;
            wrap_next    = 1'b0;
        end

        tick_mid = restart ? '0 : tick_reg;
        quo_mid  = restart ? '0 : quo_reg;
        rem_mid  = restart ? '0 : rem_reg;

        if (active_next && (tick_mid >= boundary_next))
        begin
            idx_ext       = {4'b0000, idx_next};
            led_next      = column_pattern(img_low_reg, img_high_reg, idx_ext[3:0]);
            boundary_next = boundary_next + interval_next;
            if (idx_next >= IDX_LAST)
            begin
                active_next = 1'b0;
            end
            idx_next = idx_next + SIW'(1);
        end

        if (tick_mid == CNT_MAX)
        begin
            tick_next = '0;
            quo_next  = '0;
            rem_next  = '0;
            wrap_next = 1'b1;
        end
        else
        begin
            tick_next = tick_mid + CW'(1);
            if (rem_mid == REM_LAST)
            begin
                rem_next = '0;
                quo_next = quo_mid + CW'(1);
            end
            else
            begin
                rem_next = rem_mid + RW'(1);
                quo_next = quo_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_low_reg  <= IMAGE_LOW_RESET;
            img_high_reg <= IMAGE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_LOW:  img_low_reg  <= cfg_data;
                REG_IMAGE_HIGH: img_high_reg <= cfg_data;
                default:        img_low_reg  <= img_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            wrap_reg     <= 1'b0;
            timeout_reg  <= 1'b1;
            held_reg     <= 1'b0;
            active_reg   <= 1'b0;
            interval_reg <= '0;
            boundary_reg <= '0;
            idx_reg      <= '0;
            led_reg      <= '0;
            ind_reg      <= 1'b0;
        end
        else if (accept)
        begin
            tick_reg     <= tick_next;
            quo_reg      <= quo_next;
            rem_reg      <= rem_next;
            wrap_reg     <= wrap_next;
            timeout_reg  <= timeout_next;
            held_reg     <= held_next;
            active_reg   <= active_next;
            interval_reg <= interval_next;
            boundary_reg <= boundary_next;
            idx_reg      <= idx_next;
            led_reg      <= led_next;
            ind_reg      <= ind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {6'b000000, timeout_next, ind_next, led_next};
        end
    end

endmodule

>>> sv/povst_checker.sv
module povst_checker
    import povst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled output word stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Output word changed while stalled.");

    // The input is held off only while an output word waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("Input ready does not follow the output register.");

    // Every accepted input word yields an output word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("Accepted word produced no result.");

    // No output word appears without an input word before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("Result without an accepted input word.");

    // Padding bits of the output word stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:10] == '0)
        else $error("Output padding bits are not zero.");

endmodule

bind pov_sector_timing_controller povst_checker u_povst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
